### sv/arm_pkg.sv
// Shared types, constants and codes for the address range map table.
`default_nettype none
package arm_pkg;
	localparam int RegionCount = 64;
	localparam int PageShift = 12;
	localparam int AddrBits = 39;
	localparam int PageBits = 27;
	localparam int IdxBits = $clog2(RegionCount + 1);
	localparam int SlotBits = $clog2(RegionCount);
	localparam logic [IdxBits-1:0] LinkNone = IdxBits'(RegionCount);

	typedef logic [PageBits-1:0] page_t;
	typedef logic [IdxBits-1:0] idx_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BADARG = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_NOBACK = 3'd3,
		ST_FULL = 3'd4,
		ST_UNMAPPED = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_MSTEP, S_MEVAL, S_MINS, S_MNEXT, S_MLAST, S_MDONE,
		S_USKIP, S_UCOV, S_USCAN, S_UCHK, S_UWALK, S_UACT, S_DONE, S_CLR
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // latch request
		logic init;      // start walk at list head
		logic rd;        // read entry at cur pointer
		logic adv;       // advance past read entry to its link
		logic ffupd;     // first fit: raise bp to entry end
		logic covupd;    // unmap coverage update
		logic splitchk;  // accumulate split flag
		logic ins;       // insert new region
		logic mnext;     // merge with next
		logic mlast;     // merge with previous
		logic uact;      // perform unmap action on read entry
		logic clr;       // free-chain init step
		logic done;      // emit result
		status_t st;
	} cmd_t;

	typedef struct packed {
		logic is_unmap;
		logic arg_bad;
		logic range_bad;
		logic zero_addr;
		logic at_end;      // cur pointer is none
		logic ff_fit;      // read entry leaves gap
		logic ff_fail;
		logic ex_stop;     // read end > bp
		logic ex_ovl;
		logic pool_empty;
		logic back_ok;
		logic can_mnext;
		logic can_mlast;
		logic cov_done;
		logic cov_gap;
		logic uskip_stop;
		logic split;
		logic ustop;       // unmap action walk should stop
		logic clr_last;
	} stat_t;
endpackage
`default_nettype wire

### sv/arm_datapath.sv
// Region table storage, walk pointers and request arithmetic.
`default_nettype none
module arm_datapath
	import arm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output stat_t stat,
	input wire logic opcode,
	input wire logic [AddrBits-1:0] begin_addr,
	input wire logic [PageBits-1:0] page_count,
	input wire logic [7:0] perm_bits,
	input wire logic backing_ok,
	input wire page_t wb,
	input wire page_t we,
	output logic [2:0] status,
	output logic [AddrBits-1:0] result_addr,
	output logic done
);
	page_t mem_b[RegionCount];
	page_t mem_e[RegionCount];
	logic [2:0] mem_p[RegionCount];
	idx_t mem_l[RegionCount];

	logic op_q, back_q, split_q;
	logic [AddrBits-1:0] addr_q;
	logic [PageBits:0] cnt_q;
	logic [2:0] perm_q;
	logic [PageBits:0] bp_q, cur_q;
	idx_t head_q, free_q, cur_idx_q, last_q, next_q, new_q, prev_q;
	page_t rb_q, re_q;
	logic [2:0] rp_q;
	idx_t rl_q;
	logic [SlotBits-1:0] clr_q;

	logic [7:0] perm_bits_q;
	page_t nb_q;
	logic [PageBits:0] lend_q;
	logic [2:0] np_q, lp_q;
	page_t ne_q;
	idx_t nl_q;

	// next-entry fields captured on each read of a valid entry
	page_t ne_e_q;
	idx_t nlink_q;

	logic [PageBits:0] span, ep, ne, bpc;
	logic [SlotBits-1:0] ci;
	assign span = (we >= wb) ? {1'b0, we - wb} : '0;
	assign ep = bp_q + cnt_q;
	assign ci = cur_idx_q[SlotBits-1:0];
	assign ne = bp_q + cnt_q;
	assign bpc = {1'b0, rb_q} - bp_q;

	always_comb begin
		stat = '0;
		stat.is_unmap = op_q;
		stat.zero_addr = (addr_q == '0);
		stat.arg_bad = op_q ?
			(cnt_q == 0 || addr_q[PageShift-1:0] != '0 || bp_q < {1'b0, wb} ||
			cnt_q > span || bp_q > {1'b0, we} || cnt_q > {1'b0, we} - bp_q) :
			(cnt_q == 0 || cnt_q > span || !perm_bits_q[1] || (perm_bits_q & 8'hF1) != 0 ||
			(addr_q != '0 && addr_q[PageShift-1:0] != '0));
		stat.range_bad = addr_q[PageShift-1:0] != '0 ? 1'b0 :
			(bp_q < {1'b0, wb} || bp_q > {1'b0, we} || cnt_q > {1'b0, we} - bp_q);
		stat.at_end = (cur_idx_q == LinkNone);
		stat.ff_fit = ({1'b0, rb_q} >= bp_q) && (cnt_q <= bpc);
		stat.ff_fail = (bp_q > {1'b0, we}) || (cnt_q > {1'b0, we} - bp_q);
		stat.ex_stop = ({1'b0, re_q} > bp_q);
		stat.ex_ovl = (last_q != LinkNone && lend_q > bp_q) ||
			(next_q != LinkNone && ne > {1'b0, nb_q});
		stat.pool_empty = (free_q == LinkNone);
		stat.back_ok = back_q;
		stat.can_mnext = (next_q != LinkNone) && (ne == {1'b0, nb_q}) && (np_q == perm_q);
		stat.can_mlast = (last_q != LinkNone) && (lend_q == bp_q) && (lp_q == perm_q);
		stat.cov_done = (cur_q >= ep);
		stat.cov_gap = ({1'b0, rb_q} > cur_q);
		stat.uskip_stop = ({1'b0, re_q} > cur_q);
		stat.split = split_q;
		stat.ustop = ({1'b0, rb_q} >= ep);
		stat.clr_last = (clr_q == SlotBits'(RegionCount - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= LinkNone;
			free_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.done;
			if (cmd.clr) begin
				mem_l[clr_q] <= (clr_q == SlotBits'(RegionCount - 1)) ? LinkNone :
					IdxBits'(clr_q) + 1'b1;
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				op_q <= opcode;
				addr_q <= begin_addr;
				cnt_q <= {1'b0, page_count};
				perm_bits_q <= perm_bits;
				perm_q <= perm_bits[3:1];
				back_q <= backing_ok;
				bp_q <= (opcode || begin_addr != '0) ?
					(PageBits+1)'(begin_addr >> PageShift) : {1'b0, wb};
				cur_q <= (PageBits+1)'(begin_addr >> PageShift);
				split_q <= 1'b0;
			end
			if (cmd.init) begin
				cur_idx_q <= head_q;
				last_q <= LinkNone;
				prev_q <= LinkNone;
			end
			if (cmd.rd) begin
				rb_q <= mem_b[ci];
				re_q <= mem_e[ci];
				rp_q <= mem_p[ci];
				rl_q <= mem_l[ci];
			end
			if (cmd.ffupd && {1'b0, re_q} > bp_q) bp_q <= {1'b0, re_q};
			if (cmd.adv) begin
				last_q <= cur_idx_q;
				lend_q <= {1'b0, re_q};
				lp_q <= rp_q;
				cur_idx_q <= rl_q;
			end
			if (cmd.covupd) begin
				if ({1'b0, re_q} > cur_q) cur_q <= ({1'b0, re_q} < ep) ? {1'b0, re_q} : ep;
			end
			if (cmd.splitchk && {1'b0, rb_q} < bp_q && {1'b0, re_q} > ep) split_q <= 1'b1;
			// insert new region from the free chain head
			if (cmd.ins) begin
				new_q <= free_q;
				free_q <= mem_l[free_q[SlotBits-1:0]];
				mem_b[free_q[SlotBits-1:0]] <= bp_q[PageBits-1:0];
				mem_e[free_q[SlotBits-1:0]] <= ne[PageBits-1:0];
				mem_p[free_q[SlotBits-1:0]] <= perm_q;
				mem_l[free_q[SlotBits-1:0]] <= next_q;
				if (last_q == LinkNone) head_q <= free_q;
				else mem_l[last_q[SlotBits-1:0]] <= free_q;
				ne_q <= ne[PageBits-1:0];
				nl_q <= next_q;
			end
			if (cmd.mnext) begin
				mem_e[new_q[SlotBits-1:0]] <= ne_e_q;
				mem_l[new_q[SlotBits-1:0]] <= nlink_q;
				ne_q <= ne_e_q;
				nl_q <= nlink_q;
				mem_l[next_q[SlotBits-1:0]] <= free_q;
				free_q <= next_q;
			end
			if (cmd.mlast) begin
				mem_e[last_q[SlotBits-1:0]] <= ne_q;
				mem_l[last_q[SlotBits-1:0]] <= nl_q;
				mem_l[new_q[SlotBits-1:0]] <= free_q;
				free_q <= new_q;
			end
			if (cmd.uact) begin
				if ({1'b0, re_q} <= bp_q) begin
					prev_q <= cur_idx_q;
					cur_idx_q <= rl_q;
				end else if ({1'b0, rb_q} < bp_q && {1'b0, re_q} > ep) begin
					mem_b[free_q[SlotBits-1:0]] <= ep[PageBits-1:0];
					mem_e[free_q[SlotBits-1:0]] <= re_q;
					mem_p[free_q[SlotBits-1:0]] <= rp_q;
					mem_l[free_q[SlotBits-1:0]] <= rl_q;
					free_q <= mem_l[free_q[SlotBits-1:0]];
					mem_e[ci] <= bp_q[PageBits-1:0];
					mem_l[ci] <= free_q;
					cur_idx_q <= LinkNone;
				end else if ({1'b0, rb_q} < bp_q) begin
					mem_e[ci] <= bp_q[PageBits-1:0];
					prev_q <= cur_idx_q;
					cur_idx_q <= rl_q;
				end else if ({1'b0, re_q} > ep) begin
					mem_b[ci] <= ep[PageBits-1:0];
					cur_idx_q <= LinkNone;
				end else begin
					if (prev_q == LinkNone) head_q <= rl_q;
					else mem_l[prev_q[SlotBits-1:0]] <= rl_q;
					mem_l[ci] <= free_q;
					free_q <= cur_idx_q;
					cur_idx_q <= rl_q;
				end
			end
			if (cmd.done) begin
				status <= cmd.st;
				result_addr <= (cmd.st == ST_OK && !op_q) ?
					AddrBits'(bp_q[PageBits-1:0]) << PageShift : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			next_q <= cur_idx_q;
		end
		if (cmd.rd && cur_idx_q != LinkNone) begin
			nb_q <= mem_b[ci];
			np_q <= mem_p[ci];
			ne_e_q <= mem_e[ci];
			nlink_q <= mem_l[ci];
		end
	end
endmodule
`default_nettype wire

### sv/arm_ctrl.sv
// Sequencing state machine for map and unmap requests.
`default_nettype none
module arm_ctrl
	import arm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire stat_t stat,
	output cmd_t cmd
);
	state_t state_q, state_d;
	status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		unique case (state_q)
			S_CLR: if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: if (start) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.arg_bad) begin
					st_d = ST_BADARG;
					state_d = S_DONE;
				end else if (stat.is_unmap) begin
					state_d = S_USKIP;
				end else if (!stat.zero_addr && stat.range_bad) begin
					st_d = ST_NOSPACE;
					state_d = S_DONE;
				end else begin
					state_d = S_MSTEP;
				end
			end
			S_MSTEP: state_d = S_MEVAL;
			S_MEVAL: begin
				if (stat.at_end || (stat.zero_addr ? stat.ff_fit : stat.ex_stop))
					state_d = S_MINS;
				else state_d = S_MSTEP;
			end
			S_MINS: begin
				if (stat.zero_addr ? stat.ff_fail : stat.ex_ovl) begin
					st_d = ST_NOSPACE; state_d = S_DONE;
				end else if (stat.pool_empty) begin
					st_d = ST_FULL; state_d = S_DONE;
				end else if (!stat.back_ok) begin
					st_d = ST_NOBACK; state_d = S_DONE;
				end else begin
					st_d = ST_OK; state_d = S_MNEXT;
				end
			end
			S_MNEXT: state_d = S_MLAST;
			S_MLAST: state_d = S_MDONE;
			S_MDONE: state_d = S_DONE;
			S_USKIP: state_d = S_UCOV;
			S_UCOV: begin
				if (!stat.at_end && !stat.uskip_stop) state_d = S_USKIP;
				else state_d = S_USCAN;
			end
			S_USCAN: begin
				if (stat.cov_done) state_d = S_UCHK;
				else if (stat.at_end || stat.cov_gap) begin
					st_d = ST_UNMAPPED; state_d = S_DONE;
				end else state_d = S_USKIP;
			end
			S_UCHK: begin
				if (!stat.at_end) state_d = S_UCHK;
				else if (stat.split && stat.pool_empty) begin
					st_d = ST_FULL; state_d = S_DONE;
				end else state_d = S_UWALK;
			end
			S_UWALK: state_d = S_UACT;
			S_UACT: begin
				if (stat.at_end || stat.ustop) begin
					st_d = ST_OK; state_d = S_DONE;
				end else state_d = S_UWALK;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [2:0] usub_q;
	always_comb begin
		cmd = '0;
		cmd.st = st_q;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_CLR: cmd.clr = 1'b1;
			S_IDLE: if (start) begin cmd.load = 1'b1; cmd.init = 1'b1; end
			S_CHECK: cmd.init = 1'b1;
			S_MSTEP: cmd.rd = 1'b1;
			S_MEVAL: if (!(stat.at_end || (stat.zero_addr ? stat.ff_fit : stat.ex_stop))) begin
				cmd.adv = 1'b1;
				cmd.ffupd = stat.zero_addr;
			end
			S_MINS: if (!(stat.zero_addr ? stat.ff_fail : stat.ex_ovl) &&
				!stat.pool_empty && stat.back_ok) cmd.ins = 1'b1;
			S_MNEXT: cmd.mnext = stat.can_mnext;
			S_MLAST: cmd.mlast = stat.can_mlast;
			S_USKIP: cmd.rd = 1'b1;
			S_UCOV: if (!stat.at_end && !stat.uskip_stop) cmd.adv = 1'b1;
			S_USCAN: if (!stat.cov_done && !(stat.at_end || stat.cov_gap)) begin
				cmd.covupd = 1'b1; cmd.adv = 1'b1;
			end else if (stat.cov_done) cmd.init = 1'b1;
			S_UCHK: begin
				cmd.rd = !stat.at_end;
				if (stat.at_end) cmd.init = 1'b1;
			end
			S_UWALK: cmd.rd = 1'b1;
			S_UACT: cmd.uact = !(stat.at_end || stat.ustop);
			S_DONE: cmd.done = 1'b1;
			default: ;
		endcase
		// split scan: check previously read entry, then advance
		if (state_q == S_UCHK && usub_q[0]) begin
			cmd.splitchk = 1'b1; cmd.adv = 1'b1; cmd.rd = 1'b0;
		end
		if (state_q == S_USCAN && !stat.cov_done && !(stat.at_end || stat.cov_gap))
			cmd.rd = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) usub_q <= '0;
		else if (state_q == S_UCHK) usub_q <= usub_q + 1'b1;
		else usub_q <= '0;
	end
endmodule
`default_nettype wire

### sv/address_range_map_unmap_table_core.sv
// Top level of the address range map/unmap table.
// An argument error goes straight to the result; a map walks the regions that it passes and
// an unmap walks the region list. One item at a time; busy drops in the cycle of the
// result strobe. After reset a pass builds the free chain while busy is high.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
module address_range_map_unmap_table_core
	import arm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic opcode,
	input wire logic [AddrBits-1:0] begin_addr,
	input wire logic [PageBits-1:0] page_count,
	input wire logic [7:0] perm_bits,
	input wire logic backing_ok,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [PageBits-1:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [AddrBits-1:0] result_addr
);
	cmd_t cmd;
	stat_t stat;
	page_t wb_q, we_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= PageBits'(65536);
			we_q <= PageBits'(98304);
		end else if (cfg_valid) begin
			if (cfg_index) we_q <= cfg_data;
			else wb_q <= cfg_data;
		end
	end

	arm_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .stat, .cmd);
	arm_datapath u_dp (.clk, .arst_n, .cmd, .stat, .opcode, .begin_addr, .page_count,
		.perm_bits, .backing_ok, .wb(wb_q), .we(we_q), .status, .result_addr, .done);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result while busy");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_UNMAPPED)) else $error("bad status");
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (result_addr == '0)) else $error("addr on error");
endmodule
`default_nettype wire

### tb/sv/tb_address_range_map_unmap_table_core.sv
// Testbench for the address range map/unmap table: directed table plus random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_address_range_map_unmap_table_core;
	import arm_pkg::*;

	localparam int WatchdogLimit = 200000;
	localparam logic OP_MAP = 1'b0;
	localparam logic OP_UNMAP = 1'b1;
	localparam logic REG_WIN_BEGIN = 1'b0;
	localparam logic REG_WIN_END = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = 1'b0;
	logic [AddrBits-1:0] begin_addr = '0;
	logic [PageBits-1:0] page_count = '0;
	logic [7:0] perm_bits = '0;
	logic backing_ok = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [PageBits-1:0] cfg_data = '0;
	logic done;
	logic [2:0] status;
	logic [AddrBits-1:0] result_addr;

	always #4 clk = ~clk;

	address_range_map_unmap_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.begin_addr(begin_addr), .page_count(page_count), .perm_bits(perm_bits),
		.backing_ok(backing_ok), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
		.result_addr(result_addr)
	);

	typedef struct packed {
		logic op;
		logic [AddrBits-1:0] addr;
		logic [PageBits-1:0] cnt;
		logic [7:0] perm;
		logic back;
	} req_t;

	typedef struct packed {
		status_t st;
		logic [AddrBits-1:0] addr;
	} answer_t;

	typedef struct {
		req_t rq;
		logic chk;
		answer_t ans;
	} row_t;

	// region table mirror
	logic [63:0] rg_b[RegionCount];
	logic [63:0] rg_e[RegionCount];
	logic [2:0] rg_p[RegionCount];
	int rg_l[RegionCount];
	int head, free_hd;
	logic [63:0] win_b, win_e;

	answer_t pending_q[$];
	int errors = 0;
	int idle_cycles = 0;

	function automatic int nxt(int i);
		return i < RegionCount ? rg_l[i] : RegionCount;
	endfunction

	function automatic int take_slot();
		int r;
		r = free_hd;
		if (r < RegionCount) free_hd = rg_l[r];
		return r;
	endfunction

	function automatic void give_slot(int r);
		if (r >= RegionCount) return;
		rg_l[r] = free_hd;
		free_hd = r;
	endfunction

	function automatic logic [63:0] span();
		return win_e >= win_b ? win_e - win_b : 0;
	endfunction

	function automatic answer_t mk(status_t s, logic [63:0] a);
		answer_t x;
		x.st = s;
		x.addr = s == ST_OK ? a[AddrBits-1:0] : '0;
		return x;
	endfunction

	function automatic answer_t predict_map(req_t q);
		logic [63:0] a, c, bp;
		int last, nx, r;
		logic [7:0] p;
		a = q.addr;
		c = q.cnt;
		p = q.perm;
		last = RegionCount;
		nx = head;
		if (c == 0 || c > span() || p[1] == 0 || (p & 8'hF1) != 0) return mk(ST_BADARG, 0);
		if (a == 0) begin
			bp = win_b;
			while (nx < RegionCount) begin
				if (bp <= rg_b[nx] && c <= rg_b[nx] - bp) break;
				if (rg_e[nx] > bp) bp = rg_e[nx];
				last = nx;
				nx = nxt(nx);
			end
			if (bp > win_e || c > win_e - bp) return mk(ST_NOSPACE, 0);
		end else begin
			if (a[PageShift-1:0] != 0) return mk(ST_BADARG, 0);
			bp = a >> PageShift;
			if (bp < win_b || bp > win_e || c > win_e - bp) return mk(ST_NOSPACE, 0);
			while (nx < RegionCount && rg_e[nx] <= bp) begin
				last = nx;
				nx = nxt(nx);
			end
			if ((last < RegionCount && rg_e[last] > bp) ||
			    (nx < RegionCount && bp + c > rg_b[nx])) return mk(ST_NOSPACE, 0);
		end
		if (free_hd >= RegionCount) return mk(ST_FULL, 0);
		if (!q.back) return mk(ST_NOBACK, 0);
		r = take_slot();
		rg_b[r] = bp;
		rg_e[r] = bp + c;
		rg_p[r] = p[3:1];
		rg_l[r] = nx;
		if (last >= RegionCount) head = r;
		else rg_l[last] = r;
		if (nx < RegionCount && rg_e[r] == rg_b[nx] && rg_p[r] == rg_p[nx]) begin
			rg_e[r] = rg_e[nx];
			rg_l[r] = rg_l[nx];
			give_slot(nx);
		end
		if (last < RegionCount && rg_e[last] == rg_b[r] && rg_p[last] == rg_p[r]) begin
			rg_e[last] = rg_e[r];
			rg_l[last] = rg_l[r];
			give_slot(r);
		end
		return mk(ST_OK, bp << PageShift);
	endfunction

	function automatic answer_t predict_unmap(req_t q);
		logic [63:0] a, c, bp, ep, cur;
		int r, pv, nx, s;
		logic split;
		a = q.addr;
		c = q.cnt;
		bp = a >> PageShift;
		split = 0;
		if (c == 0 || a[PageShift-1:0] != 0 || bp < win_b || c > span() || bp > win_e ||
		    c > win_e - bp) return mk(ST_BADARG, 0);
		ep = bp + c;
		r = head;
		cur = bp;
		while (r < RegionCount && rg_e[r] <= cur) r = nxt(r);
		while (cur < ep) begin
			if (r >= RegionCount || rg_b[r] > cur) return mk(ST_UNMAPPED, 0);
			if (rg_e[r] > cur) cur = rg_e[r] < ep ? rg_e[r] : ep;
			r = nxt(r);
		end
		for (r = head; r < RegionCount; r = nxt(r))
			if (rg_b[r] < bp && rg_e[r] > ep) split = 1;
		if (split && free_hd >= RegionCount) return mk(ST_FULL, 0);
		pv = RegionCount;
		r = head;
		while (r < RegionCount && rg_b[r] < ep) begin
			nx = nxt(r);
			if (rg_e[r] <= bp) begin
				pv = r;
				r = nx;
			end else if (rg_b[r] < bp && rg_e[r] > ep) begin
				s = take_slot();
				if (s < RegionCount) begin
					rg_b[s] = ep;
					rg_e[s] = rg_e[r];
					rg_p[s] = rg_p[r];
					rg_l[s] = nx;
					rg_e[r] = bp;
					rg_l[r] = s;
				end
				break;
			end else if (rg_b[r] < bp) begin
				rg_e[r] = bp;
				pv = r;
				r = nx;
			end else if (rg_e[r] > ep) begin
				rg_b[r] = ep;
				break;
			end else begin
				if (pv >= RegionCount) head = nx;
				else rg_l[pv] = nx;
				give_slot(r);
				r = nx;
			end
		end
		return mk(ST_OK, 0);
	endfunction

	// result checker
	always @(posedge clk) begin
		answer_t exp_a;
		if (done) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result st=%0d addr=%h", status, result_addr);
			end else begin
				exp_a = pending_q.pop_front();
				if (status !== exp_a.st || result_addr !== exp_a.addr) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d addr=%h got st=%0d addr=%h",
							exp_a.st, exp_a.addr, status, result_addr);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [PageBits-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_WIN_BEGIN) win_b = val;
		else win_e = val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (220) @(posedge clk);
	endtask

	int gap_left = 0;

	// send one item; checked rows push their own expectation
	task automatic send(req_t q, logic chk, answer_t ans);
		answer_t p;
		if (gap_left == 0 && $urandom_range(0, 9) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= q.op;
		begin_addr <= q.addr;
		page_count <= q.cnt;
		perm_bits <= q.perm;
		backing_ok <= q.back;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = q.op == OP_MAP ? predict_map(q) : predict_unmap(q);
		pending_q.push_back(chk ? ans : p);
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t rq(logic op, logic [AddrBits-1:0] a, logic [PageBits-1:0] c,
			logic [7:0] p, logic b);
		req_t x;
		x.op = op;
		x.addr = a;
		x.cnt = c;
		x.perm = p;
		x.back = b;
		return x;
	endfunction

	function automatic req_t rand_req();
		req_t x;
		logic [63:0] pg;
		int k;
		k = $urandom_range(0, 99);
		x.op = $urandom_range(0, 99) < 45 ? OP_UNMAP : OP_MAP;
		x.back = $urandom_range(0, 19) != 0;
		x.perm = {4'b0, 1'($urandom), 1'($urandom), 1'b1, 1'b0};
		x.cnt = $urandom_range(1, 12);
		pg = win_b + $urandom_range(0, 200);
		x.addr = AddrBits'(pg << PageShift);
		if (x.op == OP_MAP && $urandom_range(0, 3) == 0) x.addr = '0;
		if (k < 4) x.perm = 8'($urandom);
		else if (k < 7) x.cnt = PageBits'({$urandom, $urandom});
		else if (k < 10) x.addr = AddrBits'({$urandom, $urandom});
		else if (k < 12) x.addr = x.addr | AddrBits'($urandom_range(1, 4095));
		else if (k < 13) x.cnt = '0;
		return x;
	endfunction

	row_t dir_rows[$];
	answer_t none;
	localparam logic [63:0] WB = 64'd65536;

	initial begin
		row_t rw;
		logic [PageBits-1:0] cfg_vals[4][2];
		for (int i = 0; i < RegionCount; i++) begin
			rg_b[i] = 0;
			rg_e[i] = 0;
			rg_p[i] = 0;
			rg_l[i] = i + 1;
		end
		head = RegionCount;
		free_hd = 0;
		win_b = 65536;
		win_e = 98304;
		none = mk(ST_OK, 0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			'{rq(OP_MAP, 0, 0, 8'h02, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, 0, 4, 8'h04, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, 0, 4, 8'h03, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, 0, 4, 8'hF2, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, 0, '1, 8'h02, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, 39'h1000_0001, 4, 8'h02, 1), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_MAP, '1 << 12, 4, 8'h02, 1), 1'b1, mk(ST_NOSPACE, 0)},
			'{rq(OP_MAP, 39'h1000, 4, 8'h02, 1), 1'b1, mk(ST_NOSPACE, 0)},
			'{rq(OP_MAP, 0, 4, 8'h02, 0), 1'b1, mk(ST_NOBACK, 0)},
			'{rq(OP_MAP, 0, 4, 8'h02, 1), 1'b1, mk(ST_OK, WB << 12)},
			'{rq(OP_MAP, 0, 4, 8'h06, 1), 1'b0, none},
			'{rq(OP_MAP, 0, 4, 8'h02, 1), 1'b0, none},
			'{rq(OP_MAP, AddrBits'((WB + 2) << 12), 1, 8'h02, 1), 1'b1, mk(ST_NOSPACE, 0)},
			'{rq(OP_MAP, AddrBits'((WB + 20) << 12), 4, 8'h0E, 1), 1'b0, none},
			'{rq(OP_MAP, AddrBits'((98304 - 32768 + 32764) << 12), 4, 8'h02, 1), 1'b0, none},
			'{rq(OP_MAP, 0, 32768, 8'h02, 1), 1'b1, mk(ST_NOSPACE, 0)},
			'{rq(OP_UNMAP, 0, 0, 0, 0), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_UNMAP, 39'h1000_0800, 1, 0, 0), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_UNMAP, 39'h1000, 1, 0, 0), 1'b1, mk(ST_BADARG, 0)},
			'{rq(OP_UNMAP, AddrBits'((WB + 30) << 12), 1, 0, 0), 1'b1, mk(ST_UNMAPPED, 0)},
			'{rq(OP_UNMAP, AddrBits'((WB + 1) << 12), 2, 8'hFF, 1), 1'b1, mk(ST_OK, 0)},
			'{rq(OP_UNMAP, AddrBits'(WB << 12), 6, 0, 0), 1'b1, mk(ST_UNMAPPED, 0)},
			'{rq(OP_UNMAP, AddrBits'(WB << 12), 12, 0, 0), 1'b0, none},
			'{rq(OP_MAP, '1 << 12, '1, 8'h0E, 1), 1'b1, mk(ST_BADARG, 0)}
		};
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send(rw.rq, rw.chk, rw.ans);
		end
		drain();

		// window settings: reset value, start at 0, empty, top of range, back to small
		cfg_vals[0] = '{27'd0, 27'd300};
		cfg_vals[1] = '{27'd500, 27'd400};
		cfg_vals[2] = '{27'h7FFFF00, 27'h7FFFFFF};
		cfg_vals[3] = '{27'd65536, 27'd65800};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_reg(REG_WIN_BEGIN, cfg_vals[ph - 1][0]);
				write_reg(REG_WIN_END, cfg_vals[ph - 1][1]);
			end
			for (int i = 0; i < 270; i++) begin
				gap_left = gap_left > 0 ? gap_left - 1 : $urandom_range(0, 30);
				send(rand_req(), 1'b0, none);
			end
			drain();
		end
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
